// ----- hw/rtl/fbpa_pkg.sv -----
// Shared types, constants and codes for the fixed block pool allocator.
// Depends on nothing; every other file of the block refers to it by scoped names.
package fbpa_pkg;

    // Pool capacity and the widths that follow from it
    localparam int MAX_BLOCKS  = 256;
    localparam int IDX_W       = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W       = $clog2(MAX_BLOCKS + 1);
    localparam int STACK_DEPTH = 1 << IDX_W;

    // Fixed field widths
    localparam int ADDR_W      = 32;
    localparam int LOG2_W      = 5;
    localparam int BIU_W       = 9;
    localparam int CFG_IDX_W   = 2;

    // Block size exponent limits and reset values
    localparam logic [LOG2_W-1:0] LOG2_MIN   = LOG2_W'(3);
    localparam logic [LOG2_W-1:0] LOG2_MAX   = LOG2_W'(20);
    localparam logic [LOG2_W-1:0] LOG2_RESET = LOG2_W'(6);
    localparam logic [BIU_W-1:0]  BIU_RESET  = BIU_W'(256);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_BASE       = 2'd0,
        CFG_BLOCK_SIZE_LOG2 = 2'd1,
        CFG_BLOCKS_IN_USE   = 2'd2,
        CFG_UNUSED          = 2'd3
    } cfg_index_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_ALLOCATED = 2'd0,
        STATUS_FREED     = 2'd1,
        STATUS_EMPTY     = 2'd2,
        STATUS_BAD_FREE  = 2'd3
    } status_t;

    // Request mode
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Effective configuration after clamping
    typedef struct packed {
        logic [ADDR_W-1:0] pool_base;
        logic [LOG2_W-1:0] shift;
        logic [CNT_W-1:0]  count;
    } cfg_t;

    // Stack commands and status
    typedef struct packed {
        logic             push;
        logic             pop;
        logic [IDX_W-1:0] push_idx;
    } stack_ctl_t;

    typedef struct packed {
        logic             nonempty;
        logic [IDX_W-1:0] top;
    } stack_stat_t;

endpackage

// ----- hw/rtl/fbpa_cfg_regs.sv -----
// Configuration registers of the fixed block pool allocator and their clamping.
// Depends on fbpa_pkg.
module fbpa_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]     wr_data,
    output fbpa_pkg::cfg_t                  cfg
);

    logic [fbpa_pkg::ADDR_W-1:0] pool_base_reg;
    logic [fbpa_pkg::LOG2_W-1:0] log2_reg;
    logic [fbpa_pkg::BIU_W-1:0]  biu_reg;
    logic [fbpa_pkg::LOG2_W-1:0] shift_eff;
    logic [31:0]                 count_eff;

    // Write the addressed register; ignore indexes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= '0;
            log2_reg      <= fbpa_pkg::LOG2_RESET;
            biu_reg       <= fbpa_pkg::BIU_RESET;
        end
        else if (wr_en)
        begin
            unique case (fbpa_pkg::cfg_index_t'(wr_index))
                fbpa_pkg::CFG_POOL_BASE:       pool_base_reg <= wr_data;
                fbpa_pkg::CFG_BLOCK_SIZE_LOG2: log2_reg <= wr_data[fbpa_pkg::LOG2_W-1:0];
                fbpa_pkg::CFG_BLOCKS_IN_USE:   biu_reg <= wr_data[fbpa_pkg::BIU_W-1:0];
                default:                       ;
            endcase
        end
    end

    // Clamp block size exponent and block count
    always_comb
    begin
        if (log2_reg < fbpa_pkg::LOG2_MIN)
            shift_eff = fbpa_pkg::LOG2_MIN;
        else if (log2_reg > fbpa_pkg::LOG2_MAX)
            shift_eff = fbpa_pkg::LOG2_MAX;
        else
            shift_eff = log2_reg;

        if (32'(biu_reg) > 32'(fbpa_pkg::MAX_BLOCKS))
            count_eff = 32'(fbpa_pkg::MAX_BLOCKS);
        else
            count_eff = 32'(biu_reg);
    end

    assign cfg.pool_base = pool_base_reg;
    assign cfg.shift     = shift_eff;
    assign cfg.count     = count_eff[fbpa_pkg::CNT_W-1:0];

endmodule

// ----- hw/rtl/fbpa_free_stack.sv -----
// Stack of freed block indexes kept as a linked list: each stacked block's link entry
// names the block below it. Top and the entry below it are held ready so that a pop or
// push completes every cycle. Depends on fbpa_pkg.
module fbpa_free_stack
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  fbpa_pkg::stack_ctl_t    ctl,
    output fbpa_pkg::stack_stat_t   stat
);

    logic [fbpa_pkg::IDX_W-1:0] link_mem [fbpa_pkg::STACK_DEPTH];

    logic [fbpa_pkg::CNT_W-1:0] count_reg,     count_next;
    logic [fbpa_pkg::IDX_W-1:0] top_reg,       top_next;
    logic [fbpa_pkg::IDX_W-1:0] below_reg,     below_next;
    logic                       below_mem_reg, below_mem_next;
    logic [fbpa_pkg::IDX_W-1:0] link_q_reg;
    logic [fbpa_pkg::IDX_W-1:0] below;

    // Entry below the top: old top after a push, link read back after a pop
    assign below = below_mem_reg ? link_q_reg : below_reg;

    // Next count, top and entry below the top
    always_comb
    begin
        count_next     = count_reg;
        top_next       = top_reg;
        below_next     = below_reg;
        below_mem_next = below_mem_reg;
        if (ctl.push)
        begin
            top_next       = ctl.push_idx;
            below_next     = top_reg;
            below_mem_next = 1'b0;
            if (count_reg != fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS))
                count_next = count_reg + fbpa_pkg::CNT_W'(1);
        end
        else if (ctl.pop)
        begin
            top_next       = below;
            below_mem_next = 1'b1;
            count_next     = count_reg - fbpa_pkg::CNT_W'(1);
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            top_reg       <= '0;
            below_reg     <= '0;
            below_mem_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            top_reg       <= top_next;
            below_reg     <= below_next;
            below_mem_reg <= below_mem_next;
        end
    end

    // Link the pushed block to the old top; on a pop fetch the link of the new top
    always_ff @(posedge clk)
    begin
        if (ctl.push)
            link_mem[ctl.push_idx] <= top_reg;
        if (ctl.pop)
            link_q_reg <= link_mem[below];
    end

    assign stat.nonempty = (count_reg != '0);
    assign stat.top      = top_reg;

endmodule

// ----- hw/rtl/fixed_block_pool_allocator.sv -----
// Top level of the fixed block pool allocator: input register, request logic,
// fresh block counter and result register. Depends on fbpa_pkg, fbpa_cfg_regs
// and fbpa_free_stack.
//
// Each request word (tuser = mode, tdata = free address) allocates or frees one
// block and yields exactly one result word (tuser = status, tdata = block address).
// A request passes first through the input register and then through the result
// register, and one request is taken every cycle while the result side keeps up.
// Freed blocks are served last-in first-out ahead of never-used blocks in
// ascending order; the freed-block stack is a linked list in a link memory that
// holds the top and the entry below it ready and reads one link per pop. Frees of
// misaligned or out-of-pool addresses are reported and ignored; double frees are
// not detected. Write configuration only while no request is in flight.
module fixed_block_pool_allocator
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // [31:0] free_address
    input  logic [0:0]                      s_tuser,   // [0] mode
    // Result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // [31:0] block_address
    output logic [1:0]                      m_tuser,   // [1:0] status
    // Configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data
);

    fbpa_pkg::cfg_t        cfg;
    fbpa_pkg::stack_ctl_t  stack_ctl;
    fbpa_pkg::stack_stat_t stack_stat;

    logic                        in_valid_reg;
    logic                        mode_reg;
    logic [fbpa_pkg::ADDR_W-1:0] addr_reg;

    logic                        out_valid_reg;
    logic [1:0]                  out_status_reg, out_status_next;
    logic [fbpa_pkg::ADDR_W-1:0] out_addr_reg,   out_addr_next;

    logic [fbpa_pkg::CNT_W-1:0]  fresh_reg, fresh_next;

    logic                        advance;
    logic                        work;
    logic [fbpa_pkg::ADDR_W-1:0] offset;
    logic [fbpa_pkg::ADDR_W-1:0] low_mask;
    logic [fbpa_pkg::ADDR_W-1:0] free_idx;
    logic [fbpa_pkg::IDX_W-1:0]  alloc_idx;

    // Configuration is taken at once
    assign cfg_ready = 1'b1;

    fbpa_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    fbpa_free_stack u_stack
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (stack_ctl),
        .stat  (stack_stat)
    );

    // Advance when the result register is empty or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign work     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            mode_reg <= s_tuser[0];
            addr_reg <= s_tdata;
        end
    end

    // Free address check
    assign offset   = addr_reg - cfg.pool_base;
    assign low_mask = (32'd1 << cfg.shift) - 32'd1;
    assign free_idx = offset >> cfg.shift;

    // Serve a request: allocate from the stack first, then fresh blocks; check and push a free
    always_comb
    begin
        stack_ctl.push     = 1'b0;
        stack_ctl.pop      = 1'b0;
        stack_ctl.push_idx = free_idx[fbpa_pkg::IDX_W-1:0];
        fresh_next         = fresh_reg;
        alloc_idx          = stack_stat.top;
        out_addr_next      = '0;
        out_status_next    = fbpa_pkg::STATUS_EMPTY;
        if (mode_reg == fbpa_pkg::MODE_ALLOC)
        begin
            priority if (stack_stat.nonempty)
            begin
                stack_ctl.pop   = work;
                out_status_next = fbpa_pkg::STATUS_ALLOCATED;
            end
            else if (fresh_reg < cfg.count)
            begin
                alloc_idx       = fresh_reg[fbpa_pkg::IDX_W-1:0];
                fresh_next      = work ? fresh_reg + fbpa_pkg::CNT_W'(1) : fresh_reg;
                out_status_next = fbpa_pkg::STATUS_ALLOCATED;
            end
            else
            begin
                out_status_next = fbpa_pkg::STATUS_EMPTY;
            end
            if (out_status_next == fbpa_pkg::STATUS_ALLOCATED)
                out_addr_next = cfg.pool_base + (32'(alloc_idx) << cfg.shift);
        end
        else
        begin
            if ((offset & low_mask) != '0 || free_idx >= 32'(cfg.count))
            begin
                out_status_next = fbpa_pkg::STATUS_BAD_FREE;
            end
            else
            begin
                stack_ctl.push  = work;
                out_status_next = fbpa_pkg::STATUS_FREED;
            end
        end
    end

    // Fresh counter and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fresh_reg <= fresh_next;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (work)
        begin
            out_status_reg <= out_status_next;
            out_addr_reg   <= out_addr_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_addr_reg;
    assign m_tuser  = out_status_reg;

endmodule
